[rtl/core/ries_pkg.sv]
// Shared constants and field widths for the random interval expression scheduler.
`default_nettype none

package ries_pkg;

  localparam int NUM_EXPRESSIONS = 22;

  localparam int TIME_W = 32;
  localparam int DUR_W  = 24;
  localparam int SPAN_W = DUR_W + 1;
  localparam int RAND_W = 31;
  localparam int CMD_W  = 5;
  localparam int CNT_W  = $clog2(RAND_W);

  localparam int IN_W   = 96;
  localparam int OUT_W  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPR_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPR_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_MAX  = 3'd4;

  localparam logic [CMD_W-1:0] NO_PICK   = 5'd31;
  localparam logic [CMD_W-1:0] CMD_NEUTRAL = 5'd0;
  localparam logic [CMD_W-1:0] LAST_IDX  = CMD_W'(NUM_EXPRESSIONS - 1);

endpackage

`default_nettype wire

[rtl/core/random_interval_expression_scheduler_unit.sv]
// Top level of the random interval expression scheduler with a bit-serial remainder unit.
//
// Usage: one input word per millisecond tick arrives on the s_ channel; every accepted
// word yields exactly one result word on the m_ channel (emit flag and command).
// The configuration port writes the enable bit and the four phase limits; any write
// of the enable register returns the schedule to its armed-again reset state.
// Configuration must be written by the user only while the block is idle; not enforced.
// Steps: a tick that issues nothing (disabled, held, or not yet due) goes from ST_CHECK
// straight to ST_DONE. A tick that draws a duration passes ST_CHECK, ST_SPAN, ST_DIV,
// ST_ADD, ST_FINISH and ST_DONE; in ST_DIV the remainder of the random word by the span
// (and of the pick word by the number of expressions) is formed one bit per cycle over
// all 31 bits in a shift-subtract loop. One item is in flight at a time: s_tready is
// high only in ST_IDLE, so the next word is taken only after the result is written.
// The result sits in an output register; while the receiver stalls it holds there,
// s_tready stays low until the next result has been written, and nothing is lost.
// Reset (synchronous, active high) clears the configuration registers and the output
// register, disables the scheduler and sets the schedule to need arming with no
// previous pick.
`default_nettype none

module random_interval_expression_scheduler_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // now_time[31:0], reacting_hold[32], training_hold[33], rand_first[64:34],
  // rand_second[95:65]
  input  wire logic [ries_pkg::IN_W-1:0]       s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // emit[0], command[5:1], zero fill[7:6]
  output logic [ries_pkg::OUT_W-1:0]           m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [ries_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ries_pkg::DUR_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SPAN, ST_DIV, ST_ADD, ST_FINISH, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MODE_ARM, MODE_NEUTRAL, MODE_EXPR
  } mode_t;

  state_t state;
  mode_t  mode;

  logic                             enable;
  logic [ries_pkg::DUR_W-1:0]       expr_min_time;
  logic [ries_pkg::DUR_W-1:0]       expr_max_time;
  logic [ries_pkg::DUR_W-1:0]       neutral_min_time;
  logic [ries_pkg::DUR_W-1:0]       neutral_max_time;

  logic                             needs_arming;
  logic                             in_expression;
  logic [ries_pkg::TIME_W-1:0]      due_time;
  logic [ries_pkg::CMD_W-1:0]       last_pick;

  logic [ries_pkg::TIME_W-1:0]      now_time;
  logic                             held;
  logic [ries_pkg::RAND_W-1:0]      rand_first;
  logic [ries_pkg::RAND_W-1:0]      rand_second;

  logic [ries_pkg::DUR_W-1:0]       lo;
  logic [ries_pkg::DUR_W-1:0]       hi;
  logic [ries_pkg::SPAN_W-1:0]      span;
  logic [ries_pkg::RAND_W-1:0]      dividend;
  logic [ries_pkg::DUR_W-1:0]       rem;
  logic [ries_pkg::RAND_W-1:0]      pick_sh;
  logic [ries_pkg::CMD_W-1:0]       pick_rem;
  logic [ries_pkg::CNT_W-1:0]       count;
  logic [ries_pkg::SPAN_W-1:0]      offset;
  logic                             res_emit;
  logic [ries_pkg::CMD_W-1:0]       res_cmd;

  logic [ries_pkg::SPAN_W-1:0]      trial;
  logic [ries_pkg::DUR_W-1:0]       rem_next;
  logic [ries_pkg::CMD_W:0]         ptrial;
  logic [ries_pkg::CMD_W-1:0]       pick_rem_next;
  logic [ries_pkg::CMD_W-1:0]       pick;
  logic [ries_pkg::DUR_W-1:0]       top;
  logic                             not_due;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    trial = {rem, dividend[ries_pkg::RAND_W-1]};
    if (trial >= span) begin
      rem_next = ries_pkg::DUR_W'(trial - span);
    end else begin
      rem_next = trial[ries_pkg::DUR_W-1:0];
    end
    ptrial = {pick_rem, pick_sh[ries_pkg::RAND_W-1]};
    if (ptrial >= (ries_pkg::CMD_W+1)'(ries_pkg::NUM_EXPRESSIONS)) begin
      pick_rem_next = ries_pkg::CMD_W'(ptrial - (ries_pkg::CMD_W+1)'(ries_pkg::NUM_EXPRESSIONS));
    end else begin
      pick_rem_next = ptrial[ries_pkg::CMD_W-1:0];
    end
    if (pick_rem == last_pick) begin
      pick = (pick_rem == ries_pkg::LAST_IDX) ? '0 : pick_rem + 1'b1;
    end else begin
      pick = pick_rem;
    end
    top = (hi < lo) ? lo : hi;
    not_due = (due_time != '0) && (now_time < due_time);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      mode             <= MODE_ARM;
      m_tvalid         <= 1'b0;
      m_tdata          <= '0;
      enable           <= 1'b0;
      expr_min_time    <= '0;
      expr_max_time    <= '0;
      neutral_min_time <= '0;
      neutral_max_time <= '0;
      needs_arming     <= 1'b1;
      in_expression    <= 1'b0;
      due_time         <= '0;
      last_pick        <= ries_pkg::NO_PICK;
    end else begin
      if (m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            now_time    <= s_tdata[31:0];
            held        <= s_tdata[32] | s_tdata[33];
            rand_first  <= s_tdata[64:34];
            rand_second <= s_tdata[95:65];
            state       <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          res_emit <= 1'b0;
          res_cmd  <= ries_pkg::CMD_NEUTRAL;
          lo       <= neutral_min_time;
          hi       <= neutral_max_time;
          dividend <= rand_first;
          if (!enable || held) begin
            state <= ST_DONE;
          end else if (needs_arming) begin
            mode  <= MODE_ARM;
            state <= ST_SPAN;
          end else if (not_due) begin
            state <= ST_DONE;
          end else if (in_expression) begin
            mode  <= MODE_NEUTRAL;
            state <= ST_SPAN;
          end else begin
            mode     <= MODE_EXPR;
            lo       <= expr_min_time;
            hi       <= expr_max_time;
            dividend <= rand_second;
            state    <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          span     <= {1'b0, top} - {1'b0, lo} + 1'b1;
          rem      <= '0;
          pick_rem <= '0;
          pick_sh  <= rand_first;
          count    <= '0;
          state    <= ST_DIV;
        end
        ST_DIV: begin
          rem      <= rem_next;
          pick_rem <= pick_rem_next;
          dividend <= {dividend[ries_pkg::RAND_W-2:0], 1'b0};
          pick_sh  <= {pick_sh[ries_pkg::RAND_W-2:0], 1'b0};
          count    <= count + 1'b1;
          if (count == ries_pkg::CNT_W'(ries_pkg::RAND_W - 1)) begin
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          offset <= {1'b0, lo} + {1'b0, rem};
          state  <= ST_FINISH;
        end
        ST_FINISH: begin
          due_time <= now_time + ries_pkg::TIME_W'(offset);
          case (mode)
            MODE_ARM: begin
              needs_arming  <= 1'b0;
              in_expression <= 1'b0;
            end
            MODE_NEUTRAL: begin
              in_expression <= 1'b0;
              res_emit      <= 1'b1;
            end
            MODE_EXPR: begin
              last_pick     <= pick;
              in_expression <= 1'b1;
              res_emit      <= 1'b1;
              res_cmd       <= pick + 1'b1;
            end
            default: begin
            end
          endcase
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, res_cmd, res_emit};
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_we) begin
        case (cfg_index)
          ries_pkg::REG_ENABLE: begin
            enable        <= cfg_data[0];
            needs_arming  <= 1'b1;
            in_expression <= 1'b0;
            due_time      <= '0;
            last_pick     <= ries_pkg::NO_PICK;
          end
          ries_pkg::REG_EXPR_MIN:    expr_min_time    <= cfg_data;
          ries_pkg::REG_EXPR_MAX:    expr_max_time    <= cfg_data;
          ries_pkg::REG_NEUTRAL_MIN: neutral_min_time <= cfg_data;
          ries_pkg::REG_NEUTRAL_MAX: neutral_max_time <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/ries_checker.sv]
// Port-level checker for the scheduler and its bind to the top level.
`default_nettype none

module ries_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [ries_pkg::OUT_W-1:0] m_tdata
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_no_emit_no_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[5:1] == ries_pkg::CMD_NEUTRAL)
    else $error("command set on a word without emit");

  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[5:1] <= ries_pkg::CMD_W'(ries_pkg::NUM_EXPRESSIONS))
    else $error("command beyond the expression count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid right after reset");

endmodule

bind random_interval_expression_scheduler_unit ries_checker u_ries_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/random_interval_expression_scheduler_unit_tb.sv]
// Self-checking testbench for the random interval expression scheduler: directed and random ticks.
`timescale 1ns / 100ps

module random_interval_expression_scheduler_unit_tb;
  import ries_pkg::*;

  typedef struct packed {
    logic [RAND_W-1:0] rand_second;
    logic [RAND_W-1:0] rand_first;
    logic              training_hold;
    logic              reacting_hold;
    logic [TIME_W-1:0] now_time;
  } tick_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             emit;
  } sched_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DUR_W-1:0]     cfg_data = '0;

  logic             sched_enable = 1'b0;
  logic [DUR_W-1:0] expr_lo = '0;
  logic [DUR_W-1:0] expr_hi = '0;
  logic [DUR_W-1:0] neut_lo = '0;
  logic [DUR_W-1:0] neut_hi = '0;

  logic              awaiting_arm = 1'b1;
  logic              showing_expr = 1'b0;
  logic [TIME_W-1:0] next_due = '0;
  logic [CMD_W-1:0]  prev_pick = NO_PICK;

  sched_out_t pending_results[$];
  int         mismatch_count = 0;
  int         burst_left = 0;
  int         ready_mode = 0;
  int         ready_left = 0;

  random_interval_expression_scheduler_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void restart_schedule();
    awaiting_arm = 1'b1;
    showing_expr = 1'b0;
    next_due = '0;
    prev_pick = NO_PICK;
  endfunction

  function automatic logic [TIME_W-1:0] phase_length(input logic [DUR_W-1:0] lo,
                                                      input logic [DUR_W-1:0] hi,
                                                      input logic [RAND_W-1:0] rnd);
    logic [TIME_W-1:0] span;
    span = TIME_W'(hi < lo ? lo : hi) - TIME_W'(lo) + 1;
    return TIME_W'(lo) + TIME_W'(rnd) % span;
  endfunction

  function automatic sched_out_t schedule_tick(input tick_t t);
    sched_out_t       r;
    logic [CMD_W-1:0] pick;
    r.emit = 1'b0;
    r.command = CMD_NEUTRAL;
    if (!sched_enable || t.reacting_hold || t.training_hold) return r;
    if (awaiting_arm) begin
      awaiting_arm = 1'b0;
      showing_expr = 1'b0;
      next_due = t.now_time + phase_length(neut_lo, neut_hi, t.rand_first);
      return r;
    end
    if (next_due != 0 && t.now_time < next_due) return r;
    r.emit = 1'b1;
    if (showing_expr) begin
      showing_expr = 1'b0;
      next_due = t.now_time + phase_length(neut_lo, neut_hi, t.rand_first);
      return r;
    end
    pick = CMD_W'(t.rand_first % NUM_EXPRESSIONS);
    if (pick == prev_pick) pick = CMD_W'((pick + 1) % NUM_EXPRESSIONS);
    prev_pick = pick;
    showing_expr = 1'b1;
    next_due = t.now_time + phase_length(expr_lo, expr_hi, t.rand_second);
    r.command = pick + 1'b1;
    return r;
  endfunction

  function automatic tick_t make_tick(input logic [TIME_W-1:0] now_ms, input logic react,
                                      input logic train, input logic [RAND_W-1:0] r1,
                                      input logic [RAND_W-1:0] r2);
    tick_t t;
    t.now_time = now_ms;
    t.reacting_hold = react;
    t.training_hold = train;
    t.rand_first = r1;
    t.rand_second = r2;
    return t;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE: begin
        sched_enable = value[0];
        restart_schedule();
      end
      REG_EXPR_MIN: expr_lo = value;
      REG_EXPR_MAX: expr_hi = value;
      REG_NEUTRAL_MIN: neut_lo = value;
      REG_NEUTRAL_MAX: neut_hi = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [DUR_W-1:0] n_lo, input logic [DUR_W-1:0] n_hi,
                            input logic [DUR_W-1:0] e_lo, input logic [DUR_W-1:0] e_hi);
    write_reg(REG_NEUTRAL_MIN, n_lo);
    write_reg(REG_NEUTRAL_MAX, n_hi);
    write_reg(REG_EXPR_MIN, e_lo);
    write_reg(REG_EXPR_MAX, e_hi);
    write_reg(REG_ENABLE, 24'd1);
  endtask

  // The word stays on the bus after acceptance unless a gap starts, so back-to-back
  // words are sent without dropping s_tvalid between them.
  task automatic send_tick(input tick_t t);
    s_tvalid <= 1'b1;
    s_tdata <= t;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(schedule_tick(t));
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 45)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(20, 300);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk) begin : check_results
    sched_out_t got;
    sched_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = sched_out_t'(m_tdata[$bits(sched_out_t)-1:0]);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: emit %0d command %0d", got.emit, got.command);
      end else begin
        want = pending_results.pop_front();
        if (got.emit !== want.emit || got.command !== want.command) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected emit %0d command %0d, got emit %0d command %0d",
                     want.emit, want.command, got.emit, got.command);
        end
      end
    end
  end

  task automatic test_disabled_ticks();
    send_tick(make_tick('0, 1'b0, 1'b0, '0, '0));
    send_tick(make_tick('1, 1'b1, 1'b1, '1, '1));
    settle();
  endtask

  task automatic test_phase_cycle();
    set_limits(24'd10, 24'd10, 24'd5, 24'd5);
    send_tick(make_tick(32'd100, 1'b0, 1'b0, 31'd7, '0));
    send_tick(make_tick(32'd105, 1'b0, 1'b0, 31'd3, '0));
    send_tick(make_tick(32'd110, 1'b0, 1'b0, 31'd21, 31'd9));
    send_tick(make_tick(32'd115, 1'b0, 1'b0, 31'd4, '0));
    // The last pick comes up again and has to step around to the first index.
    send_tick(make_tick(32'd125, 1'b0, 1'b0, 31'd43, '1));
    send_tick(make_tick(32'd200, 1'b1, 1'b0, '1, '1));
    send_tick(make_tick(32'd200, 1'b0, 1'b1, '1, '1));
    send_tick(make_tick(32'd200, 1'b0, 1'b0, '1, '0));
    settle();
  endtask

  task automatic test_enable_rewrite();
    write_reg(REG_ENABLE, 24'hFFFFFF);
    send_tick(make_tick(32'd300, 1'b0, 1'b0, '0, '0));
    settle();
    write_reg(REG_ENABLE, 24'hFFFFFE);
    send_tick(make_tick(32'd400, 1'b0, 1'b0, '0, '0));
    settle();
    write_reg(REG_ENABLE, 24'd1);
    send_tick(make_tick(32'd500, 1'b0, 1'b0, 31'd2, '0));
    settle();
  endtask

  task automatic test_unused_index();
    for (int i = int'(REG_NEUTRAL_MAX) + 1; i < 2 ** CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), '1);
    send_tick(make_tick(32'd1000, 1'b0, 1'b0, 31'd12, 31'd1));
    settle();
  endtask

  task automatic test_zero_and_wrapped_due();
    set_limits('0, '0, '0, '0);
    send_tick(make_tick('0, 1'b0, 1'b0, '0, '0));
    send_tick(make_tick('0, 1'b0, 1'b0, '0, '0));
    send_tick(make_tick('0, 1'b0, 1'b0, '0, '0));
    settle();
    write_reg(REG_NEUTRAL_MIN, 24'd1);
    write_reg(REG_NEUTRAL_MAX, 24'd1);
    write_reg(REG_EXPR_MIN, 24'd1);
    write_reg(REG_EXPR_MAX, 24'd1);
    send_tick(make_tick('1, 1'b0, 1'b0, 31'd5, 31'd6));
    send_tick(make_tick(32'd5, 1'b0, 1'b0, 31'd8, '0));
    settle();
  endtask

  task automatic test_max_below_min();
    set_limits(24'hFFFFFF, 24'd3, 24'h800000, '0);
    send_tick(make_tick(32'hFFFFFF00, 1'b0, 1'b0, '1, '0));
    send_tick(make_tick('0, 1'b0, 1'b0, '0, '0));
    send_tick(make_tick(32'h00FFFEFF, 1'b0, 1'b0, '1, '1));
    send_tick(make_tick('1, 1'b0, 1'b0, 31'd17, '0));
    settle();
  endtask

  task automatic test_full_span();
    set_limits('0, 24'hFFFFFF, '0, 24'hFFFFFF);
    send_tick(make_tick('0, 1'b0, 1'b0, '1, '0));
    send_tick(make_tick(32'h01000000, 1'b0, 1'b0, 31'h2AAAAAAA, '1));
    settle();
  endtask

  task automatic test_random_schedule();
    logic [TIME_W-1:0] clock_ms;
    logic [DUR_W-1:0]  lo [4];
    logic [DUR_W-1:0]  hi [4];
    tick_t             t;
    for (int setting = 0; setting < 10; setting++) begin
      for (int k = 0; k < 4; k++) begin
        lo[k] = DUR_W'($urandom_range(0, 40));
        hi[k] = ($urandom_range(0, 4) == 0) ? DUR_W'($urandom_range(0, 40))
                                             : lo[k] + DUR_W'($urandom_range(0, 40));
      end
      set_limits(lo[0], hi[0], lo[1], hi[1]);
      clock_ms = ($urandom_range(0, 2) == 0) ? '1 - $urandom_range(0, 200) : $urandom();
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 39) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(0, 8);
        t.now_time = clock_ms;
        t.reacting_hold = ($urandom_range(0, 11) == 0);
        t.training_hold = ($urandom_range(0, 11) == 0);
        t.rand_first = RAND_W'($urandom());
        t.rand_second = RAND_W'($urandom());
        if ($urandom_range(0, 5) == 0 && prev_pick != NO_PICK)
          t.rand_first = RAND_W'(prev_pick + NUM_EXPRESSIONS * $urandom_range(0, 1000));
        send_tick(t);
      end
      settle();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_disabled_ticks();
    test_phase_cycle();
    test_enable_rewrite();
    test_unused_index();
    test_zero_and_wrapped_due();
    test_max_below_min();
    test_full_span();
    test_random_schedule();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
